/* hdl/rsd_pkg.sv */
// shared types, constants and GF(32) arithmetic for the shortened RS(31,23) decoder
// field polynomial x^5 + x^2 + 1, primitive element alpha = 2
// no dependencies
package rsd_pkg;

	localparam int NN     = 31;
	localparam int CORR_T = 4;
	localparam int NPAR   = 2 * CORR_T;
	localparam int KK     = NN - NPAR;
	localparam int ADDR_W = 6;

	typedef logic [4:0] sym_t;
	typedef logic [NPAR-1:0][4:0] syn_vec_t;

	localparam logic [1:0] ST_CLEAN = 2'd0;
	localparam logic [1:0] ST_FIXED = 2'd1;
	localparam logic [1:0] ST_FAIL  = 2'd2;

	// alpha^e for e = 0..30, entry 31 wraps to alpha^0
	localparam sym_t ALOG [32] = '{
		5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd5,  5'd10, 5'd20,
		5'd13, 5'd26, 5'd17, 5'd7,  5'd14, 5'd28, 5'd29, 5'd31,
		5'd27, 5'd19, 5'd3,  5'd6,  5'd12, 5'd24, 5'd21, 5'd15,
		5'd30, 5'd25, 5'd23, 5'd11, 5'd22, 5'd9,  5'd18, 5'd1
	};

	// multiplicative inverse, zero maps to zero
	localparam sym_t INV [32] = '{
		5'd0,  5'd1,  5'd18, 5'd28, 5'd9,  5'd23, 5'd14, 5'd12,
		5'd22, 5'd4,  5'd25, 5'd16, 5'd7,  5'd15, 5'd6,  5'd13,
		5'd11, 5'd24, 5'd2,  5'd29, 5'd30, 5'd26, 5'd8,  5'd5,
		5'd17, 5'd10, 5'd21, 5'd31, 5'd3,  5'd19, 5'd20, 5'd27
	};

	typedef struct packed {
		syn_vec_t   syn;
		logic [4:0] len;
		logic       bank;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic sym_t gf_mul(input sym_t a, input sym_t b);
		sym_t r;
		sym_t x;
		r = '0;
		x = a;
		for (int k = 0; k < 5; k++) begin
			if (b[k]) r ^= x;
			x = {x[3:0], 1'b0} ^ (x[4] ? 5'h05 : 5'h00);
		end
		return r;
	endfunction

	function automatic sym_t gf_inv(input sym_t a);
		return INV[a];
	endfunction

	function automatic sym_t gf_alog(input logic [4:0] e);
		return ALOG[e];
	endfunction

	// (a + b) mod 31 for a, b below 31
	function automatic logic [4:0] add_mod(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'(NN)) s = s - 6'(NN);
		return s[4:0];
	endfunction

endpackage

/* hdl/rsd_front.sv */
// front end: takes symbols, keeps the length register, accumulates syndromes
// and holds message symbols in a two-bank buffer read by the back end
// depends on rsd_pkg
module rsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rsd_pkg::sym_t symbol,
	input  logic          cfg_wen,
	input  logic [4:0]    cfg_wdata,
	output logic          q_push,
	output rsd_pkg::desc_t q_desc,
	input  logic [5:0]    rd_addr,
	output rsd_pkg::sym_t rd_data,
	input  rsd_pkg::rel_t rel
);
	import rsd_pkg::*;

	logic [4:0] ml_q;
	logic [4:0] cnt_q;
	logic       wr_bank_q;
	logic [1:0] used_q;
	sym_t       pw_q  [NPAR];
	sym_t       syn_q [NPAR];
	sym_t       mem   [2**ADDR_W];

	logic [4:0] eff_len;
	logic       accept;
	logic       last_sym;
	logic       is_par;
	sym_t       cur_pw [NPAR];
	syn_vec_t   syn_n;

	always_comb begin
		if (ml_q == 5'd0) eff_len = 5'd1;
		else if (ml_q > 5'(KK)) eff_len = 5'(KK);
		else eff_len = ml_q;
	end

	// no symbol transfer in a cycle that writes the length register
	assign full     = used_q[wr_bank_q] | cfg_wen;
	assign accept   = push & ~full;
	assign last_sym = (cnt_q == 5'(eff_len + 5'(NPAR - 1)));
	assign is_par   = (cnt_q >= eff_len);

	// per-syndrome running power alpha^((i+1)*position)
	always_comb begin
		for (int i = 0; i < NPAR; i++) begin
			if (cnt_q == 5'd0) cur_pw[i] = ALOG[5'((NPAR * (i + 1)) % NN)];
			else if (cnt_q == eff_len) cur_pw[i] = 5'd1;
			else cur_pw[i] = pw_q[i];
			syn_n[i] = ((cnt_q == 5'd0) ? 5'd0 : syn_q[i]) ^ gf_mul(symbol, cur_pw[i]);
		end
	end

	assign q_push      = accept & last_sym;
	assign q_desc.syn  = syn_n;
	assign q_desc.len  = eff_len;
	assign q_desc.bank = wr_bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_q      <= 5'd12;
			cnt_q     <= '0;
			wr_bank_q <= 1'b0;
			used_q    <= '0;
		end else begin
			if (cfg_wen) begin
				ml_q  <= cfg_wdata;
				cnt_q <= '0;
			end else if (accept) begin
				cnt_q <= last_sym ? 5'd0 : 5'(cnt_q + 5'd1);
				if (last_sym) wr_bank_q <= ~wr_bank_q;
			end
			for (int b = 0; b < 2; b++) begin
				if (accept && last_sym && !cfg_wen && (wr_bank_q == 1'(b))) used_q[b] <= 1'b1;
				else if (rel.valid && (rel.bank == 1'(b))) used_q[b] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cfg_wen) begin
			for (int i = 0; i < NPAR; i++) begin
				pw_q[i]  <= gf_mul(cur_pw[i], ALOG[5'(i + 1)]);
				syn_q[i] <= syn_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cfg_wen && !is_par) mem[{wr_bank_q, cnt_q}] <= symbol;
		rd_data <= mem[rd_addr];
	end

endmodule

/* hdl/rsd_queue.sv */
// two-entry queue of word descriptors between front and back end
// depends on rsd_pkg
module rsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_push,
	input  rsd_pkg::desc_t q_desc,
	input  logic           q_pop,
	output logic           q_empty,
	output rsd_pkg::desc_t q_head
);
	import rsd_pkg::*;

	desc_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_empty = (count_q == 2'd0);
	assign q_head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (q_push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop && !q_empty) rd_ptr_q <= ~rd_ptr_q;
			unique case ({q_push, q_pop && !q_empty})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) slot_q[wr_ptr_q] <= q_desc;
	end

endmodule

/* hdl/rsd_back.sv */
// back end: Berlekamp-Massey, Chien search, Forney, then streams the corrected
// message out of the front end buffer into an output register
// depends on rsd_pkg
module rsd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  rsd_pkg::desc_t q_head,
	output logic           q_pop,
	output logic [5:0]     rd_addr,
	input  rsd_pkg::sym_t  rd_data,
	output rsd_pkg::rel_t  rel,
	output logic           empty,
	input  logic           pop,
	output rsd_pkg::sym_t  symbol_res,
	output logic           last,
	output logic [1:0]     status
);
	import rsd_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_CHECK    = 12'b000000000010,
		S_BM_D     = 12'b000000000100,
		S_BM_F     = 12'b000000001000,
		S_BM_U     = 12'b000000010000,
		S_BM_END   = 12'b000000100000,
		S_CHIEN    = 12'b000001000000,
		S_CH_END   = 12'b000010000000,
		S_FOR_INIT = 12'b000100000000,
		S_FOR_STEP = 12'b001000000000,
		S_FOR_MAG  = 12'b010000000000,
		S_OUT      = 12'b100000000000
	} state_t;

	state_t     state_q;
	syn_vec_t   syn_q;
	logic [4:0] len_q;
	logic       bank_q;
	sym_t       loc_q   [NPAR+1];
	sym_t       prior_q [NPAR+1];
	logic [3:0] deg_q;
	logic [3:0] m_q;
	logic [2:0] n_q;
	sym_t       b_q;
	sym_t       d_q;
	sym_t       f_q;
	sym_t       term_q  [CORR_T+1];
	logic [4:0] ci_q;
	logic [2:0] cnt_q;
	sym_t       root_q  [CORR_T];
	sym_t       pos_q   [CORR_T];
	sym_t       ev_q    [CORR_T];
	logic [2:0] fi_q;
	logic [2:0] fk_q;
	sym_t       x_q;
	sym_t       p_q;
	sym_t       num_q;
	sym_t       den_q;
	sym_t       mag_q   [CORR_T];
	logic [1:0] status_q;
	logic [4:0] k_q;
	logic [4:0] k_rd_q;
	logic       pend_q;
	logic       ov_q;
	sym_t       res_q;
	logic       last_q;
	logic [1:0] st_out_q;

	sym_t       d_c;
	sym_t       loc_n [NPAR+1];
	logic       grow;
	sym_t       chien_v;
	sym_t       ev_c  [CORR_T];
	sym_t       den_term;
	sym_t       corr;
	logic       issue;
	logic       last_rd;

	// discrepancy of step n
	always_comb begin
		d_c = syn_q[n_q];
		for (int i = 1; i < NPAR; i++) begin
			if ((deg_q >= 4'(i)) && ({1'b0, n_q} >= 4'(i)))
				d_c ^= gf_mul(loc_q[i], syn_q[3'(n_q - 3'(i))]);
		end
	end

	always_comb begin
		for (int k = 0; k <= NPAR; k++) begin
			loc_n[k] = loc_q[k];
			if (4'(k) >= m_q) loc_n[k] ^= gf_mul(f_q, prior_q[4'(4'(k) - m_q)]);
		end
	end

	assign grow = ({deg_q, 1'b0} <= {2'b00, n_q});

	always_comb begin
		chien_v = '0;
		for (int j = 0; j <= CORR_T; j++) begin
			if (deg_q >= 4'(j)) chien_v ^= term_q[j];
		end
	end

	// evaluator coefficients 1..T, ev_c[i-1] holds coefficient i
	always_comb begin
		for (int i = 1; i <= CORR_T; i++) begin
			ev_c[i-1] = syn_q[i-1] ^ loc_q[i];
			for (int j = 1; j < i; j++) ev_c[i-1] ^= gf_mul(loc_q[i-j], syn_q[j-1]);
		end
	end

	assign den_term = 5'd1 ^ gf_alog(add_mod(pos_q[fk_q[1:0]], root_q[fi_q[1:0]]));

	always_comb begin
		corr = '0;
		for (int e = 0; e < CORR_T; e++) begin
			if ((status_q == ST_FIXED) && (4'(e) < deg_q)
			    && (pos_q[e] == 5'(5'(NPAR) + k_rd_q)))
				corr ^= mag_q[e];
		end
	end

	assign issue     = (state_q == S_OUT) && !pend_q && (k_q != len_q) && (!ov_q || pop);
	assign last_rd   = (k_rd_q == 5'(len_q - 5'd1));
	assign rd_addr   = {bank_q, k_q};
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign rel.valid = pend_q && last_rd;
	assign rel.bank  = bank_q;

	assign empty      = ~ov_q;
	assign symbol_res = res_q;
	assign last       = last_q;
	assign status     = st_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			pend_q <= issue;
			if (pend_q) ov_q <= 1'b1;
			else if (pop && ov_q) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE:     if (!q_empty) state_q <= S_CHECK;
				S_CHECK:    state_q <= (syn_q == '0) ? S_OUT : S_BM_D;
				S_BM_D: begin
					if (d_c != 5'd0) state_q <= S_BM_F;
					else if (n_q == 3'(NPAR - 1)) state_q <= S_BM_END;
				end
				S_BM_F:     state_q <= S_BM_U;
				S_BM_U:     state_q <= (n_q == 3'(NPAR - 1)) ? S_BM_END : S_BM_D;
				S_BM_END:   state_q <= (deg_q > 4'(CORR_T)) ? S_OUT : S_CHIEN;
				S_CHIEN:    if (ci_q == 5'(NN)) state_q <= S_CH_END;
				S_CH_END:   state_q <= ({1'b0, cnt_q} != deg_q) ? S_OUT : S_FOR_INIT;
				S_FOR_INIT: state_q <= ({1'b0, fi_q} == deg_q) ? S_OUT : S_FOR_STEP;
				S_FOR_STEP: if (4'(4'(fk_q) + 4'd1) == deg_q) state_q <= S_FOR_MAG;
				S_FOR_MAG:  state_q <= S_FOR_INIT;
				S_OUT:      if (pend_q && last_rd) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					syn_q  <= q_head.syn;
					len_q  <= q_head.len;
					bank_q <= q_head.bank;
				end
				k_q <= '0;
			end
			S_CHECK: begin
				status_q <= ST_CLEAN;
				for (int k = 0; k <= NPAR; k++) begin
					loc_q[k]   <= (k == 0) ? 5'd1 : 5'd0;
					prior_q[k] <= (k == 0) ? 5'd1 : 5'd0;
				end
				deg_q <= '0;
				m_q   <= 4'd1;
				n_q   <= '0;
				b_q   <= 5'd1;
			end
			S_BM_D: begin
				d_q <= d_c;
				if (d_c == 5'd0) begin
					m_q <= 4'(m_q + 4'd1);
					n_q <= 3'(n_q + 3'd1);
				end
			end
			S_BM_F: f_q <= gf_mul(d_q, gf_inv(b_q));
			S_BM_U: begin
				loc_q <= loc_n;
				if (grow) begin
					deg_q   <= 4'(4'(n_q) + 4'd1 - deg_q);
					prior_q <= loc_q;
					b_q     <= d_q;
					m_q     <= 4'd1;
				end else begin
					m_q <= 4'(m_q + 4'd1);
				end
				n_q <= 3'(n_q + 3'd1);
			end
			S_BM_END: begin
				status_q <= ST_FAIL;
				for (int j = 0; j <= CORR_T; j++) term_q[j] <= gf_mul(loc_q[j], ALOG[j]);
				ci_q  <= 5'd1;
				cnt_q <= '0;
			end
			S_CHIEN: begin
				if (chien_v == 5'd0) begin
					if (cnt_q < 3'(CORR_T)) begin
						root_q[cnt_q[1:0]] <= (ci_q == 5'(NN)) ? 5'd0 : ci_q;
						pos_q[cnt_q[1:0]]  <= (ci_q == 5'(NN)) ? 5'd0 : 5'(5'(NN) - ci_q);
					end
					if (cnt_q <= 3'(CORR_T)) cnt_q <= 3'(cnt_q + 3'd1);
				end
				for (int j = 0; j <= CORR_T; j++) term_q[j] <= gf_mul(term_q[j], ALOG[j]);
				ci_q <= 5'(ci_q + 5'd1);
			end
			S_CH_END: begin
				status_q <= ({1'b0, cnt_q} != deg_q) ? ST_FAIL : ST_FIXED;
				ev_q     <= ev_c;
				fi_q     <= '0;
			end
			S_FOR_INIT: begin
				x_q   <= gf_alog(root_q[fi_q[1:0]]);
				p_q   <= gf_alog(root_q[fi_q[1:0]]);
				num_q <= 5'd1;
				den_q <= 5'd1;
				fk_q  <= '0;
			end
			S_FOR_STEP: begin
				num_q <= num_q ^ gf_mul(ev_q[fk_q[1:0]], p_q);
				p_q   <= gf_mul(p_q, x_q);
				if (fk_q != fi_q) den_q <= gf_mul(den_q, den_term);
				fk_q  <= 3'(fk_q + 3'd1);
			end
			S_FOR_MAG: begin
				mag_q[fi_q[1:0]] <= gf_mul(num_q, gf_inv(den_q));
				fi_q <= 3'(fi_q + 3'd1);
			end
			S_OUT: begin
				if (issue) begin
					k_rd_q <= k_q;
					k_q    <= 5'(k_q + 5'd1);
				end
			end
			default: k_q <= '0;
		endcase
		if (pend_q) begin
			res_q    <= rd_data ^ corr;
			last_q   <= last_rd;
			st_out_q <= status_q;
		end
	end

endmodule

/* hdl/rs_gf32_shortened_decoder_unit.sv */
// top level of the shortened RS(31,23) decoder over GF(32), up to four symbol errors
// depends on rsd_pkg, rsd_front, rsd_queue, rsd_back
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------
//  input    | push / full           | symbol[4:0]
//  result   | pop / empty           | symbol_res[4:0], last, status[1:0]
//  config   | cfg_wen               | cfg_wdata[4:0] (message length)
//
// symbols are taken one per cycle while full is low; a word holds len+8 symbols.
// the back end then runs Berlekamp-Massey, the Chien search over 31 positions and
// Forney, and reads the message symbols one at a time out of the single read port of
// the message buffer, issuing each read only after the last one's data is registered.
// the two-bank buffer lets the next word load while the back end works; full rises
// when both banks hold words and during a length write. reset sets the message
// length to 12 and empties all.
module rs_gf32_shortened_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [4:0]          symbol,
	input  logic                pop,
	output logic                empty,
	output logic [4:0]          symbol_res,
	output logic                last,
	output logic [1:0]          status,
	input  logic                cfg_wen,
	input  logic [4:0]          cfg_wdata
);
	import rsd_pkg::*;

	logic       q_push;
	desc_t      q_desc;
	logic       q_pop;
	logic       q_empty;
	desc_t      q_head;
	logic [5:0] rd_addr;
	sym_t       rd_data;
	rel_t       rel;

	rsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.symbol    (symbol),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_push    (q_push),
		.q_desc    (q_desc),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.rel       (rel)
	);

	rsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_desc  (q_desc),
		.q_pop   (q_pop),
		.q_empty (q_empty),
		.q_head  (q_head)
	);

	rsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.rel        (rel),
		.empty      (empty),
		.pop        (pop),
		.symbol_res (symbol_res),
		.last       (last),
		.status     (status)
	);

endmodule
